// ----- rtl/chs_pkg.sv -----
`timescale 1ns / 1ps
// Package for the chained hash set unit: sizes, command codes and job types.
// Holds the key-to-bucket table, which is built when the design is elaborated.
// Depends on nothing; every other file imports it.
package chs_pkg;

    localparam int BUCKETS     = 19;
    localparam int HASH_TERMS  = 5;
    localparam int CHAIN_SLOTS = 21;
    localparam int QUEUE_DEPTH = 2;

    localparam int KEY_W     = 7;
    localparam int BUCKET_W  = 5;
    localparam int KEY_COUNT = 2 ** KEY_W;
    localparam int FILL_W    = $clog2(CHAIN_SLOTS + 1);
    localparam int ADDR_W    = $clog2(BUCKETS * CHAIN_SLOTS);
    localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef logic [BUCKET_W-1:0] t_bucket_tbl [0:KEY_COUNT-1];

    typedef struct packed {
        logic                command;
        logic [KEY_W-1:0]    key_value;
        logic [BUCKET_W-1:0] bucket;
    } t_job;

    typedef struct packed {
        logic [BUCKET_W-1:0] bucket;
        logic                found;
        logic                stored;
        logic                chain_full;
    } t_result;

    function automatic t_bucket_tbl build_bucket_tbl();
        t_bucket_tbl tbl;
        int acc;
        int pw;
        int x;
        for (int k = 0; k < KEY_COUNT; k++) begin
            acc = 0;
            pw  = 1 % BUCKETS;
            x   = k % BUCKETS;
            for (int i = 0; i < HASH_TERMS; i++) begin
                acc = (acc + ((i % BUCKETS) * pw) % BUCKETS) % BUCKETS;
                pw  = (pw * x) % BUCKETS;
            end
            tbl[k] = BUCKET_W'(acc);
        end
        return tbl;
    endfunction

    localparam t_bucket_tbl BUCKET_TBL = build_bucket_tbl();

endpackage

// ----- rtl/chs_if.sv -----
`timescale 1ns / 1ps
// Channel interfaces for the chained hash set unit: commands in, results out.
// Depends on chs_pkg for the field widths.
interface chs_in_if import chs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             command;
    logic [KEY_W-1:0] key_value;

    modport source (output valid, command, key_value, input ready);
    modport sink (input valid, command, key_value, output ready);
endinterface

interface chs_out_if import chs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [BUCKET_W-1:0] bucket;
    logic                found;
    logic                stored;
    logic                chain_full;

    modport source (output valid, bucket, found, stored, chain_full, input ready);
    modport sink (input valid, bucket, found, stored, chain_full, output ready);
endinterface

// ----- rtl/chs_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts commands, looks up the bucket and queues the job.
// Depends on chs_pkg for the bucket table and the job type.
module chs_front import chs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_command,
    input  logic [KEY_W-1:0] i_key_value,
    output logic             o_job_valid,
    input  logic             i_job_ready,
    output t_job             o_job
);

    t_job              r_queue [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              push;
    logic              pop;
    t_job              new_job;

    assign o_ready     = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_job_valid = (r_count != '0);
    assign o_job       = r_queue[r_rd_ptr];
    assign push        = i_valid && o_ready;
    assign pop         = o_job_valid && i_job_ready;

    always_comb begin
        new_job.command   = i_command;
        new_job.key_value = i_key_value;
        new_job.bucket    = BUCKET_TBL[i_key_value];
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= new_job;
        end
    end

endmodule

// ----- rtl/chs_back.sv -----
`timescale 1ns / 1ps
// Back end: holds the chain slots and fill counts, carries out inserts and
// walks chains for queries, one slot read per cycle. Depends on chs_pkg.
module chs_back import chs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_job_valid,
    output logic    o_job_ready,
    input  t_job    i_job,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_result o_res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [KEY_W-1:0]    r_slot_mem [0:BUCKETS*CHAIN_SLOTS-1];
    logic [FILL_W-1:0]   r_chain_fill [0:BUCKETS-1];
    logic [KEY_W-1:0]    r_rdata;

    logic [1:0]          r_state, n_state;
    logic                r_cmd, n_cmd;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [BUCKET_W-1:0] r_bucket, n_bucket;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [ADDR_W-1:0]   r_base, n_base;
    logic [FILL_W-1:0]   r_s, n_s;
    logic                r_rd_vld, n_rd_vld;
    logic                r_found, n_found;
    logic                r_stored, n_stored;
    logic                r_full, n_full;
    logic                r_out_vld, n_out_vld;
    t_result             r_out, n_out;

    logic                rd_en;
    logic                wr_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wr_addr;

    assign o_job_ready = (r_state == S_IDLE);
    assign o_res_valid = r_out_vld;
    assign o_res       = r_out;
    assign rd_addr     = r_base + ADDR_W'(r_s);
    assign wr_addr     = r_base + ADDR_W'(r_fill);

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_bucket  = r_bucket;
        n_fill    = r_fill;
        n_base    = r_base;
        n_s       = r_s;
        n_rd_vld  = 1'b0;
        n_found   = r_found;
        n_stored  = r_stored;
        n_full    = r_full;
        n_out_vld = r_out_vld;
        n_out     = r_out;
        rd_en     = 1'b0;
        wr_en     = 1'b0;

        if (r_out_vld && i_res_ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_cmd    = i_job.command;
                    n_key    = i_job.key_value;
                    n_bucket = i_job.bucket;
                    n_fill   = r_chain_fill[i_job.bucket];
                    n_base   = ADDR_W'(i_job.bucket) * ADDR_W'(CHAIN_SLOTS);
                    n_s      = '0;
                    n_found  = 1'b0;
                    n_stored = 1'b0;
                    n_full   = 1'b0;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_cmd == CMD_INSERT) begin
                    if (r_fill >= FILL_W'(CHAIN_SLOTS)) begin
                        n_full = 1'b1;
                    end else begin
                        wr_en    = 1'b1;
                        n_stored = 1'b1;
                    end
                    n_state = S_RESP;
                end else if (r_rd_vld && (r_rdata == r_key)) begin
                    n_found = 1'b1;
                    n_state = S_RESP;
                end else if (r_s < r_fill) begin
                    rd_en    = 1'b1;
                    n_s      = r_s + 1'b1;
                    n_rd_vld = 1'b1;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (!r_out_vld || i_res_ready) begin
                    n_out_vld        = 1'b1;
                    n_out.bucket     = r_bucket;
                    n_out.found      = r_found;
                    n_out.stored     = r_stored;
                    n_out.chain_full = r_full;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int b = 0; b < BUCKETS; b++) begin
                r_chain_fill[b] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
            if (wr_en) begin
                r_chain_fill[r_bucket] <= r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_bucket <= n_bucket;
        r_fill   <= n_fill;
        r_base   <= n_base;
        r_s      <= n_s;
        r_found  <= n_found;
        r_stored <= n_stored;
        r_full   <= n_full;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot_mem[wr_addr] <= r_key;
        end
        if (rd_en) begin
            r_rdata <= r_slot_mem[rd_addr];
        end
    end

endmodule

// ----- rtl/chained_hash_set_unit.sv -----
`timescale 1ns / 1ps
// Chained hash set unit: top level joining the front end queue and the back end.
// A query reads chain slots until it finds the key or reaches the chain fill, which is at
// most 21 slots. The back end serves one command at a time and so sets the throughput;
// the two-entry queue absorbs stalls.
// Synchronous active-low reset clears all fill counts; slot contents are kept.
module chained_hash_set_unit import chs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    chs_in_if.sink    i_in,
    chs_out_if.source o_out
);

    logic    job_valid;
    logic    job_ready;
    t_job    job;
    logic    res_valid;
    t_result res;

    chs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_command   (i_in.command),
        .i_key_value (i_in.key_value),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job       (job)
    );

    chs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job       (job),
        .o_res_valid (res_valid),
        .i_res_ready (o_out.ready),
        .o_res       (res)
    );

    assign o_out.valid      = res_valid;
    assign o_out.bucket     = res.bucket;
    assign o_out.found      = res.found;
    assign o_out.stored     = res.stored;
    assign o_out.chain_full = res.chain_full;

endmodule

// ----- rtl/chs_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the chained hash set unit, bound to its top level.
// Depends on chs_pkg for widths and the bucket count.
module chs_checker import chs_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [BUCKET_W-1:0] i_bucket,
    input logic                i_found,
    input logic                i_stored,
    input logic                i_chain_full
);

    a_status_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_stored && i_chain_full))
        else $error("Result reports both stored and chain full.");

    a_found_only_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_found) |-> (!i_stored && !i_chain_full))
        else $error("Query result carries an insert status.");

    a_bucket_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_bucket < BUCKET_W'(BUCKETS)))
        else $error("Result bucket lies outside the table.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_bucket)
            && $stable(i_found) && $stable(i_stored) && $stable(i_chain_full)))
        else $error("Stalled result transfer changed.");

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result valid straight after reset.");

endmodule

bind chained_hash_set_unit chs_checker u_chs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_bucket     (o_out.bucket),
    .i_found      (o_out.found),
    .i_stored     (o_out.stored),
    .i_chain_full (o_out.chain_full)
);

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for chained_hash_set_unit: insert and query commands go in, and each
// result is checked against a hash set that the bench keeps beside the unit.
// Depends on chs_pkg and the chs_in_if / chs_out_if interfaces from the RTL.
module tb;
    import chs_pkg::*;

    localparam int RANDOM_CMDS = 800;
    localparam int DRAIN_WAIT  = 60;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic             command;
        logic [KEY_W-1:0] key_value;
    } t_cmd;

    logic i_clk;
    logic i_rst_n;

    chs_in_if  in_ch ();
    chs_out_if out_ch ();

    chained_hash_set_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_cmd             cmd_backlog [$];
    t_result          due_results [$];
    int               chain_len [BUCKETS];
    logic [KEY_W-1:0] chain_keys [BUCKETS][CHAIN_SLOTS];

    int accepted_cmds;
    int fail_count;
    int cycle_count;
    int burst_left;
    int gap_left;
    int hold_left;
    bit held_once;
    int ready_mode;
    int mode_left;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int hash_bucket(input logic [KEY_W-1:0] key);
        int x;
        int acc;
        x   = int'(key) % BUCKETS;
        acc = 0;
        for (int i = HASH_TERMS - 1; i >= 0; i--) begin
            acc = (acc * x + i) % BUCKETS;
        end
        return acc;
    endfunction

    function automatic t_result apply_to_set(input logic command, input logic [KEY_W-1:0] key);
        t_result res;
        int b;
        b              = hash_bucket(key);
        res            = '0;
        res.bucket     = BUCKET_W'(b);
        if (command == CMD_INSERT) begin
            if (chain_len[b] >= CHAIN_SLOTS) begin
                res.chain_full = 1'b1;
            end else begin
                chain_keys[b][chain_len[b]] = key;
                chain_len[b]++;
                res.stored = 1'b1;
            end
        end else begin
            for (int s = 0; s < chain_len[b]; s++) begin
                if (chain_keys[b][s] == key) begin
                    res.found = 1'b1;
                end
            end
        end
        return res;
    endfunction

    function automatic void queue_cmd(input logic command, input int key);
        t_cmd c;
        c.command   = command;
        c.key_value = KEY_W'(key);
        cmd_backlog.push_back(c);
    endfunction

    // Command driver: bursts of transfers separated by random gaps.
    always @(posedge i_clk) begin : drive_cmds
        t_cmd nxt;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            burst_left  <= 0;
            gap_left    <= 0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (gap_left > 0) begin
                gap_left    <= gap_left - 1;
                in_ch.valid <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
                nxt             = cmd_backlog.pop_front();
                in_ch.valid     <= 1'b1;
                in_ch.command   <= nxt.command;
                in_ch.key_value <= nxt.key_value;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 16);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver: changing stall patterns, and one long hold-off so the unit backs up.
    always @(posedge i_clk) begin : drain_results
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_left    <= 0;
            held_once    <= 1'b0;
            ready_mode   <= 0;
            mode_left    <= 0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else if (!held_once && accepted_cmds >= 150) begin
            held_once    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode <= $urandom_range(0, 2);
                mode_left  <= $urandom_range(20, 80);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (ready_mode)
                0: begin
                    out_ch.ready <= 1'b1;
                end
                1: begin
                    out_ch.ready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    out_ch.ready <= ($urandom_range(0, 7) == 0);
                end
            endcase
        end
    end

    // Monitor: each command transfer updates the set, each result transfer is checked.
    always @(posedge i_clk) begin : watch_channels
        t_result want;
        if (!i_rst_n) begin
            accepted_cmds <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                due_results.push_back(apply_to_set(in_ch.command, in_ch.key_value));
                accepted_cmds <= accepted_cmds + 1;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (due_results.size() == 0) begin
                    $error("result transfer with no result due: bucket %0d", out_ch.bucket);
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    if (out_ch.bucket !== want.bucket) begin
                        $error("bucket: expected %0d, got %0d", want.bucket, out_ch.bucket);
                        fail_count++;
                    end
                    if (out_ch.found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, out_ch.found);
                        fail_count++;
                    end
                    if (out_ch.stored !== want.stored) begin
                        $error("stored: expected %0d, got %0d", want.stored, out_ch.stored);
                        fail_count++;
                    end
                    if (out_ch.chain_full !== want.chain_full) begin
                        $error("chain_full: expected %0d, got %0d", want.chain_full,
                               out_ch.chain_full);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : run_test
        int inserted [$];
        int key;
        int pick;
        bit cmd;
        in_ch.valid     = 1'b0;
        in_ch.command   = CMD_INSERT;
        in_ch.key_value = '0;
        out_ch.ready    = 1'b0;
        i_rst_n         = 1'b0;
        fail_count      = 0;
        cycle_count     = 0;
        for (int b = 0; b < BUCKETS; b++) begin
            chain_len[b] = 0;
        end

        // Directed part: extreme keys, a query of an absent key, then one chain driven past
        // full using keys that all share a residue and so a bucket.
        queue_cmd(CMD_INSERT, 0);
        queue_cmd(CMD_INSERT, 127);
        queue_cmd(CMD_QUERY, 127);
        queue_cmd(CMD_QUERY, 0);
        queue_cmd(CMD_QUERY, 99);
        queue_cmd(CMD_INSERT, 99);
        queue_cmd(CMD_QUERY, 99);
        for (int n = 0; n < 22; n++) begin
            queue_cmd(CMD_INSERT, 7 + 19 * (n % 7));
        end
        queue_cmd(CMD_QUERY, 121);
        queue_cmd(CMD_QUERY, 8);
        inserted = '{0, 127, 99, 7, 26, 45};

        // Random part: mostly keys already inserted or keys crowding a few buckets, so that
        // queries hit and chains fill; the rest spread over the whole 7-bit range.
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            cmd  = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                key = inserted[$urandom_range(0, inserted.size() - 1)];
            end else if (pick < 6) begin
                key = (($urandom_range(0, 1) == 0) ? 2 : 11) + 19 * $urandom_range(0, 6);
            end else begin
                key = $urandom_range(0, 127);
            end
            if (cmd == CMD_INSERT) begin
                inserted.push_back(key);
            end
            queue_cmd(cmd, key);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || in_ch.valid || due_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0 && due_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- chained_hash_set_unit.f -----
rtl/chs_pkg.sv
rtl/chs_if.sv
rtl/chs_front.sv
rtl/chs_back.sv
rtl/chained_hash_set_unit.sv
rtl/chs_checker.sv
test/tb.sv
